// ----- hdl/mec_pkg.sv -----
// Package for the Mandelbrot escape-count core: fixed-point widths, constants,
// register indexes, and the saturating add, subtract and scaling helpers.
// No dependencies.
`default_nettype none

package mec_pkg;

  // Image size and fixed-point format (signed Q4.FRAC_BITS)
  localparam int MAX_DIM   = 4096;
  localparam int DIM_W     = $clog2(MAX_DIM);
  localparam int FRAC_BITS = 28;
  localparam int FX_W      = FRAC_BITS + 4;
  localparam int PROD_W    = 2 * FX_W;
  localparam int STEP_W    = FRAC_BITS + 1;
  localparam int ITER_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = STEP_W;

  typedef logic signed [FX_W-1:0]   fx_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_STEP   = 2'd0,
    REG_Y_STEP   = 2'd1,
    REG_ITER_CAP = 2'd2
  } reg_idx_t;

  // Register reset values
  localparam logic [STEP_W-1:0] X_STEP_RST   = STEP_W'(918401);
  localparam logic [STEP_W-1:0] Y_STEP_RST   = STEP_W'(524801);
  localparam logic [ITER_W-1:0] ITER_CAP_RST = ITER_W'(256);

  // Fixed-point limits and constants
  localparam fx_t FX_MAX    = {1'b0, {(FX_W-1){1'b1}}};
  localparam fx_t FX_MIN    = {1'b1, {(FX_W-1){1'b0}}};
  localparam fx_t ONE       = FX_W'(1) << FRAC_BITS;
  localparam fx_t QUARTER   = FX_W'(1) << (FRAC_BITS - 2);
  localparam fx_t SIXTEENTH = FX_W'(1) << (FRAC_BITS - 4);
  localparam fx_t FOUR      = FX_W'(1) << (FRAC_BITS + 2);
  localparam fx_t ORIGIN_R  = -(FX_W'(5) << (FRAC_BITS - 1));
  localparam fx_t ORIGIN_I  = -(FX_W'(1) << FRAC_BITS);

  // Saturating add
  function automatic fx_t fx_add(input fx_t a, input fx_t b);
    logic signed [FX_W:0] s;
    s = (FX_W+1)'(a) + (FX_W+1)'(b);
    if (s[FX_W] != s[FX_W-1]) begin
      return s[FX_W] ? FX_MIN : FX_MAX;
    end
    return s[FX_W-1:0];
  endfunction

  // Saturating subtract
  function automatic fx_t fx_sub(input fx_t a, input fx_t b);
    logic signed [FX_W:0] s;
    s = (FX_W+1)'(a) - (FX_W+1)'(b);
    if (s[FX_W] != s[FX_W-1]) begin
      return s[FX_W] ? FX_MIN : FX_MAX;
    end
    return s[FX_W-1:0];
  endfunction

  // Scale an exact product back to Q4.FRAC_BITS: floor, then saturate
  function automatic fx_t fx_scale(input prod_t p);
    logic [FX_W-FRAC_BITS:0] hi;
    hi = p[PROD_W-1:FRAC_BITS+FX_W-1];
    if ((&hi) || !(|hi)) begin
      return p[FRAC_BITS+FX_W-1:FRAC_BITS];
    end
    return p[PROD_W-1] ? FX_MIN : FX_MAX;
  endfunction

  // Origin plus unscaled index*step product, saturated
  function automatic fx_t coord_sat(input prod_t p, input fx_t org);
    logic signed [PROD_W:0] v;
    logic [FX_W+1:0]        top;
    v   = (PROD_W+1)'(p) + (PROD_W+1)'(org);
    top = v[PROD_W:FX_W-1];
    if ((&top) || !(|top)) begin
      return v[FX_W-1:0];
    end
    return v[PROD_W] ? FX_MIN : FX_MAX;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/mec_if.sv -----
// Channel interfaces for the Mandelbrot escape-count core: pixel input,
// result output and configuration write. Depends on mec_pkg.
`default_nettype none

interface mec_pixel_if;
  logic                       valid;
  logic                       ready;
  logic [mec_pkg::DIM_W-1:0]  column;
  logic [mec_pkg::DIM_W-1:0]  row;

  modport source (output valid, output column, output row, input ready);
  modport sink   (input valid, input column, input row, output ready);
endinterface

interface mec_result_if;
  logic                       valid;
  logic                       ready;
  logic [mec_pkg::ITER_W-1:0] iteration_count;
  logic [mec_pkg::DIM_W-1:0]  pixel_column;
  logic [mec_pkg::DIM_W-1:0]  pixel_row;

  modport source (output valid, output iteration_count, output pixel_column,
                  output pixel_row, input ready);
  modport sink   (input valid, input iteration_count, input pixel_column,
                  input pixel_row, output ready);
endinterface

interface mec_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [mec_pkg::CFG_IDX_W-1:0] index;
  logic [mec_pkg::CFG_DAT_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- hdl/mandelbrot_escape_count_core.sv -----
// Mandelbrot escape-count core: one shared 32x32 multiplier under a sequencer.
// Depends on mec_pkg and the channel interfaces in mec_if.sv.
//
// One pixel item at a time. The point c is formed from column and row, tested
// against the main cardioid and the period-2 bulb, and otherwise z = z^2 + c
// is iterated until |z|^2 > 4 or the count reaches the iteration cap. All
// products go through one signed 32x32 multiplier with a registered product,
// so each iteration steps through S_IT0 to S_IT3 (three products plus the
// escape test and update). The result sits in an output register, so the next
// pixel is accepted while it waits. Configuration writes are taken in any
// cycle and must be made while idle.
`default_nettype none

module mandelbrot_escape_count_core (
  input  wire              clk,
  input  wire              rst,
  mec_pixel_if.sink        pixel,
  mec_result_if.source     result,
  mec_cfg_if.sink          cfg
);

  typedef enum logic [3:0] {
    S_IDLE, S_CX, S_CY, S_CI, S_CI2, S_MM, S_PP, S_QC, S_QM, S_CMP,
    S_IT0, S_IT1, S_IT2, S_IT3, S_DONE
  } state_t;

  state_t state;

  // Configuration registers
  logic [mec_pkg::STEP_W-1:0] x_step;
  logic [mec_pkg::STEP_W-1:0] y_step;
  logic [mec_pkg::ITER_W-1:0] iter_cap;

  // Pixel and working registers
  logic [mec_pkg::DIM_W-1:0]  col;
  logic [mec_pkg::DIM_W-1:0]  row;
  logic [mec_pkg::ITER_W-1:0] count;
  mec_pkg::fx_t cr, ci, m, pb, ci2, q, qm, bulb, rhs;
  mec_pkg::fx_t zr, zi, tw, zr2, zi2;

  // Shared multiplier
  mec_pkg::fx_t  mul_a, mul_b;
  mec_pkg::prod_t mul_p;
  mec_pkg::fx_t  p_fx;

  assign p_fx        = mec_pkg::fx_scale(mul_p);
  assign pixel.ready = (state == S_IDLE);
  assign cfg.ready   = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      x_step   <= mec_pkg::X_STEP_RST;
      y_step   <= mec_pkg::Y_STEP_RST;
      iter_cap <= mec_pkg::ITER_CAP_RST;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        mec_pkg::REG_X_STEP:   x_step   <= cfg.data;
        mec_pkg::REG_Y_STEP:   y_step   <= cfg.data;
        mec_pkg::REG_ITER_CAP: iter_cap <= cfg.data[mec_pkg::ITER_W-1:0];
        default: ;
      endcase
    end
  end

  // Select multiplier operands for the current step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_CX: begin
        mul_a = {{(mec_pkg::FX_W-mec_pkg::DIM_W){1'b0}}, col};
        mul_b = {{(mec_pkg::FX_W-mec_pkg::STEP_W){1'b0}}, x_step};
      end
      S_CY: begin
        mul_a = {{(mec_pkg::FX_W-mec_pkg::DIM_W){1'b0}}, row};
        mul_b = {{(mec_pkg::FX_W-mec_pkg::STEP_W){1'b0}}, y_step};
      end
      S_CI2: begin
        mul_a = ci;
        mul_b = ci;
      end
      S_MM: begin
        mul_a = m;
        mul_b = m;
      end
      S_PP: begin
        mul_a = pb;
        mul_b = pb;
      end
      S_QC: begin
        mul_a = mec_pkg::QUARTER;
        mul_b = ci2;
      end
      S_QM: begin
        mul_a = q;
        mul_b = qm;
      end
      S_IT0: begin
        mul_a = zr;
        mul_b = zr;
      end
      S_IT1: begin
        mul_a = zi;
        mul_b = zi;
      end
      S_IT2: begin
        mul_a = tw;
        mul_b = zi;
      end
      default: ;
    endcase
  end

  // Register the product
  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
  end

  // Sequencer, working registers and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result.valid <= 1'b0;
    end else begin
      // Drop the taken result item unless a new one loads this cycle
      if (result.valid && result.ready && (state != S_DONE)) begin
        result.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (pixel.valid) begin
            col   <= pixel.column;
            row   <= pixel.row;
            state <= S_CX;
          end
        end
        S_CX: state <= S_CY;
        S_CY: begin
          cr    <= mec_pkg::coord_sat(mul_p, mec_pkg::ORIGIN_R);
          state <= S_CI;
        end
        S_CI: begin
          ci    <= mec_pkg::coord_sat(mul_p, mec_pkg::ORIGIN_I);
          m     <= mec_pkg::fx_sub(cr, mec_pkg::QUARTER);
          pb    <= mec_pkg::fx_add(cr, mec_pkg::ONE);
          state <= S_CI2;
        end
        S_CI2: state <= S_MM;
        S_MM: begin
          ci2   <= p_fx;
          state <= S_PP;
        end
        S_PP: begin
          q     <= mec_pkg::fx_add(p_fx, ci2);
          state <= S_QC;
        end
        S_QC: begin
          bulb  <= mec_pkg::fx_add(p_fx, ci2);
          qm    <= mec_pkg::fx_add(q, m);
          state <= S_QM;
        end
        S_QM: begin
          rhs   <= p_fx;
          state <= S_CMP;
        end
        // Shape tests: answer the iteration cap at once for the cardioid or bulb
        S_CMP: begin
          if ((p_fx <= rhs) || (bulb <= mec_pkg::SIXTEENTH)) begin
            count <= iter_cap;
            state <= S_DONE;
          end else begin
            zr    <= '0;
            zi    <= '0;
            count <= '0;
            state <= S_IT0;
          end
        end
        S_IT0: begin
          if (count == iter_cap) begin
            state <= S_DONE;
          end else begin
            tw    <= mec_pkg::fx_add(zr, zr);
            state <= S_IT1;
          end
        end
        S_IT1: begin
          zr2   <= p_fx;
          state <= S_IT2;
        end
        S_IT2: begin
          zi2   <= p_fx;
          state <= S_IT3;
        end
        // Escape test, then advance z
        S_IT3: begin
          if (mec_pkg::fx_add(zr2, zi2) > mec_pkg::FOUR) begin
            state <= S_DONE;
          end else begin
            zr    <= mec_pkg::fx_add(mec_pkg::fx_sub(zr2, zi2), cr);
            zi    <= mec_pkg::fx_add(p_fx, ci);
            count <= count + 1'b1;
            state <= S_IT0;
          end
        end
        // Hold until the output register is free
        S_DONE: begin
          if (!result.valid || result.ready) begin
            result.valid           <= 1'b1;
            result.iteration_count <= count;
            result.pixel_column    <= col;
            result.pixel_row       <= row;
            state                  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- sim/mandelbrot_escape_count_core_test.sv -----
`timescale 1ns / 1ps

// Testbench for mandelbrot_escape_count_core. It drives pixel items and register
// writes, predicts each escape count in Q4.28 and checks every result in order.
// Depends on mec_pkg, the channel interfaces in mec_if.sv and the core itself.

module mandelbrot_escape_count_core_test;

  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 212;
  localparam int DRAIN_CYCLES  = 64;
  localparam int SETTLE_LIMIT  = 2000000;
  localparam logic [mec_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  // Escape-count predictor and the queue of results still owed by the core
  class escape_scoreboard;
    typedef struct packed {
      logic [mec_pkg::ITER_W-1:0] steps;
      logic [mec_pkg::DIM_W-1:0]  column;
      logic [mec_pkg::DIM_W-1:0]  row;
    } pixel_result_t;

    // Q4.28 limits and constants
    localparam mec_pkg::fx_t SAT_HI       = 32'sh7FFF_FFFF;
    localparam mec_pkg::fx_t SAT_LO       = 32'sh8000_0000;
    localparam mec_pkg::fx_t UNIT_FX      = 32'sh1000_0000;
    localparam mec_pkg::fx_t QUARTER_FX   = 32'sh0400_0000;
    localparam mec_pkg::fx_t SIXTEENTH_FX = 32'sh0100_0000;
    localparam mec_pkg::fx_t ESCAPE_FX    = 32'sh4000_0000;
    localparam mec_pkg::fx_t RE_START     = -32'sh2800_0000;
    localparam mec_pkg::fx_t IM_START     = -32'sh1000_0000;

    logic [mec_pkg::STEP_W-1:0] x_step;
    logic [mec_pkg::STEP_W-1:0] y_step;
    logic [mec_pkg::ITER_W-1:0] iter_cap;
    pixel_result_t owed[$];
    int errors;
    int checked;

    function new();
      x_step   = 29'd918401;
      y_step   = 29'd524801;
      iter_cap = 16'd256;
      errors   = 0;
      checked  = 0;
    endfunction

    // Mirror a register write; unknown indexes are dropped
    function void write_reg(logic [mec_pkg::CFG_IDX_W-1:0] idx,
                            logic [mec_pkg::CFG_DAT_W-1:0] value);
      case (idx)
        mec_pkg::REG_X_STEP:   x_step = value[mec_pkg::STEP_W-1:0];
        mec_pkg::REG_Y_STEP:   y_step = value[mec_pkg::STEP_W-1:0];
        mec_pkg::REG_ITER_CAP: iter_cap = value[mec_pkg::ITER_W-1:0];
        default: ;
      endcase
    endfunction

    function mec_pkg::fx_t clip(longint v);
      if (v > longint'(SAT_HI)) return SAT_HI;
      if (v < longint'(SAT_LO)) return SAT_LO;
      return mec_pkg::fx_t'(v);
    endfunction

    function mec_pkg::fx_t sat_sum(mec_pkg::fx_t a, mec_pkg::fx_t b);
      return clip(longint'(a) + longint'(b));
    endfunction

    // Exact product, floor to Q4.28, then saturate
    function mec_pkg::fx_t sat_prod(mec_pkg::fx_t a, mec_pkg::fx_t b);
      return clip((longint'(a) * longint'(b)) >>> mec_pkg::FRAC_BITS);
    endfunction

    function mec_pkg::fx_t axis_point(mec_pkg::fx_t origin,
                                      logic [mec_pkg::DIM_W-1:0] index,
                                      logic [mec_pkg::STEP_W-1:0] step);
      return clip(longint'(origin) + longint'(index) * longint'(step));
    endfunction

    // Steps survived by z = z^2 + c, with the cardioid and bulb shortcuts
    function logic [mec_pkg::ITER_W-1:0] escape_steps(mec_pkg::fx_t cr,
                                                      mec_pkg::fx_t ci);
      mec_pkg::fx_t ci2, m, q, p, zr, zi, zr2, zi2, nzr;
      int unsigned n;
      ci2 = sat_prod(ci, ci);
      m   = sat_sum(cr, -QUARTER_FX);
      q   = sat_sum(sat_prod(m, m), ci2);
      p   = sat_sum(cr, UNIT_FX);
      if (sat_prod(q, sat_sum(q, m)) <= sat_prod(QUARTER_FX, ci2)) return iter_cap;
      if (sat_sum(sat_prod(p, p), ci2) <= SIXTEENTH_FX) return iter_cap;
      zr = '0;
      zi = '0;
      for (n = 0; n < iter_cap; n++) begin
        zr2 = sat_prod(zr, zr);
        zi2 = sat_prod(zi, zi);
        if (sat_sum(zr2, zi2) > ESCAPE_FX) break;
        nzr = sat_sum(sat_sum(zr2, -zi2), cr);
        zi  = sat_sum(sat_prod(sat_sum(zr, zr), zi), ci);
        zr  = nzr;
      end
      return n[mec_pkg::ITER_W-1:0];
    endfunction

    // Predict the result of an accepted pixel and queue it
    function void note_pixel(logic [mec_pkg::DIM_W-1:0] col,
                             logic [mec_pkg::DIM_W-1:0] row);
      pixel_result_t r;
      r.steps  = escape_steps(axis_point(RE_START, col, x_step),
                              axis_point(IM_START, row, y_step));
      r.column = col;
      r.row    = row;
      owed.push_back(r);
    endfunction

    task mismatch(string msg);
      $display("%0t ns MISMATCH %s", $time, msg);
      errors++;
    endtask

    // Compare an accepted result with the oldest prediction
    task check_result(logic [mec_pkg::ITER_W-1:0] steps,
                      logic [mec_pkg::DIM_W-1:0] col,
                      logic [mec_pkg::DIM_W-1:0] row);
      pixel_result_t e;
      if (owed.size() == 0) begin
        mismatch($sformatf("unexpected result: count %0d pixel (%0d,%0d)",
                           steps, col, row));
        return;
      end
      e = owed.pop_front();
      checked++;
      if (steps !== e.steps)
        mismatch($sformatf("pixel (%0d,%0d): count %0d, expected %0d",
                           e.column, e.row, steps, e.steps));
      if (col !== e.column)
        mismatch($sformatf("pixel (%0d,%0d): column echo %0d", e.column, e.row, col));
      if (row !== e.row)
        mismatch($sformatf("pixel (%0d,%0d): row echo %0d", e.column, e.row, row));
    endtask
  endclass

  logic clk;
  logic rst;
  bit   idle_on;
  int   stall_left;
  int   pixels_sent;
  int   reg_writes;
  escape_scoreboard sb;

  mec_pixel_if  pixel_ch();
  mec_result_if result_ch();
  mec_cfg_if    cfg_ch();

  mandelbrot_escape_count_core dut (
    .clk    (clk),
    .rst    (rst),
    .pixel  (pixel_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Stop a hung run
  initial begin
    #200_000_000;
    $display("mandelbrot_escape_count_core_test: errors");
    $finish;
  end

  // Drive result ready, dropping it in random bursts
  initial begin
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        result_ch.ready <= 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 15) == 0) begin
        result_ch.ready <= 1'b0;
        stall_left = $urandom_range(0, 11);
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  // Check each accepted result item
  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready)
      sb.check_result(result_ch.iteration_count, result_ch.pixel_column,
                      result_ch.pixel_row);
  end

  // Write one register; call at a falling edge or while idle
  task automatic put_reg(input logic [mec_pkg::CFG_IDX_W-1:0] idx,
                         input logic [mec_pkg::CFG_DAT_W-1:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.write_reg(idx, value);
    reg_writes++;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Offer one pixel item, maybe after an idle burst; call at a falling edge
  task automatic send_pixel(input logic [mec_pkg::DIM_W-1:0] col,
                            input logic [mec_pkg::DIM_W-1:0] row);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      pixel_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pixel_ch.valid  <= 1'b1;
    pixel_ch.column <= col;
    pixel_ch.row    <= row;
    do @(posedge clk); while (!pixel_ch.ready);
    sb.note_pixel(col, row);
    pixels_sent++;
    @(negedge clk);
  endtask

  // Drop valid, wait for owed results up to SETTLE_LIMIT; ends at a falling edge
  task automatic settle();
    int waited;
    waited = 0;
    pixel_ch.valid <= 1'b0;
    while (sb.owed.size() != 0 && waited < SETTLE_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    @(negedge clk);
  endtask

  initial begin
    int kind;
    int w;
    int h;
    int unsigned span;
    logic [mec_pkg::DIM_W-1:0]     col;
    logic [mec_pkg::DIM_W-1:0]     row;
    logic [mec_pkg::STEP_W-1:0]    xs;
    logic [mec_pkg::STEP_W-1:0]    ys;
    logic [mec_pkg::ITER_W-1:0]    cap;
    logic [mec_pkg::CFG_DAT_W-1:0] cap_word;

    sb          = new();
    idle_on     = 1'b1;
    pixels_sent = 0;
    reg_writes  = 0;
    rst              = 1'b1;
    pixel_ch.valid   = 1'b0;
    pixel_ch.column  = '0;
    pixel_ch.row     = '0;
    result_ch.ready  = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = mec_pkg::REG_X_STEP;
    cfg_ch.data      = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset registers: corners, saturated coordinates, cardioid, bulb, cusp
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd0, 12'd4095);
    send_pixel(12'd4095, 12'd0);
    send_pixel(12'd731, 12'd512);
    send_pixel(12'd438, 12'd512);
    send_pixel(12'd292, 12'd511);
    send_pixel(12'd804, 12'd512);
    send_pixel(12'd2730, 12'd1365);
    settle();

    // Zero steps and zero cap; the spare index must change nothing
    put_reg(mec_pkg::REG_X_STEP, '0);
    put_reg(mec_pkg::REG_Y_STEP, '0);
    put_reg(mec_pkg::REG_ITER_CAP, '0);
    put_reg(REG_SPARE, '1);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'hAAA, 12'h555);
    settle();

    // Full-width steps, cap of one with junk above the cap bits
    put_reg(mec_pkg::REG_X_STEP, '1);
    put_reg(mec_pkg::REG_Y_STEP, '1);
    put_reg(mec_pkg::REG_ITER_CAP, {13'h1FFF, 16'd1});
    send_pixel(12'd1, 12'd1);
    send_pixel(12'd0, 12'd4095);
    send_pixel(12'd4095, 12'd1);
    settle();

    // Unit steps, full cap: -1.5 on the real axis runs the whole cap
    put_reg(mec_pkg::REG_X_STEP, 29'h1000_0000);
    put_reg(mec_pkg::REG_Y_STEP, 29'h1000_0000);
    put_reg(mec_pkg::REG_ITER_CAP, mec_pkg::CFG_DAT_W'(16'hFFFF));
    send_pixel(12'd2, 12'd1);
    send_pixel(12'd1, 12'd1);
    send_pixel(12'd5, 12'd3);
    send_pixel(12'd0, 12'd2);
    settle();

    // Random phases: image-shaped steps, raw steps, and the reset setting last
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      kind = ph % 3;
      if (ph == RANDOM_PHASES - 1) begin
        idle_on = 1'b0;
        xs = 29'd918401;
        ys = 29'd524801;
        cap = 16'd256;
        w = 3812;
        h = 4096;
      end else if (kind == 2) begin
        xs = mec_pkg::STEP_W'($urandom) >> $urandom_range(0, 20);
        ys = mec_pkg::STEP_W'($urandom) >> $urandom_range(0, 20);
        cap = mec_pkg::ITER_W'($urandom_range(1, 128));
        w = mec_pkg::MAX_DIM;
        h = mec_pkg::MAX_DIM;
      end else begin
        w = $urandom_range(4, mec_pkg::MAX_DIM);
        h = $urandom_range(2, mec_pkg::MAX_DIM);
        span = 939524096 / (w - 1);
        if (span > 268435456) span = 268435456;
        xs = mec_pkg::STEP_W'(span);
        span = 536870912 / (h - 1);
        if (span > 268435456) span = 268435456;
        ys = mec_pkg::STEP_W'(span);
        cap = (kind == 0) ? mec_pkg::ITER_W'($urandom_range(1, 256))
                          : mec_pkg::ITER_W'($urandom_range(1, 32));
      end
      cap_word = (kind == 1) ?
                 {(mec_pkg::CFG_DAT_W-mec_pkg::ITER_W)'($urandom), cap} :
                 mec_pkg::CFG_DAT_W'(cap);
      put_reg(mec_pkg::REG_X_STEP, xs);
      put_reg(mec_pkg::REG_Y_STEP, ys);
      put_reg(mec_pkg::REG_ITER_CAP, cap_word);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // Mostly pixels inside the image, some anywhere in the 12-bit range
        if ($urandom_range(0, 7) == 0) begin
          col = mec_pkg::DIM_W'($urandom);
          row = mec_pkg::DIM_W'($urandom);
        end else begin
          col = mec_pkg::DIM_W'($urandom_range(0, w - 1));
          row = mec_pkg::DIM_W'($urandom_range(0, h - 1));
        end
        send_pixel(col, row);
      end
      settle();
    end

    // Drain and conclude
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.owed.size() != 0)
      sb.mismatch($sformatf("%0d results never arrived", sb.owed.size()));
    $display("%0d pixel items sent, %0d results checked, %0d register writes",
             pixels_sent, sb.checked, reg_writes);
    $display("settings ran from zero steps and cap to full-width steps and a 16-bit cap");
    if (sb.errors == 0) begin
      $display("mandelbrot_escape_count_core_test: clean");
    end else begin
      $display("mandelbrot_escape_count_core_test: errors");
    end
    $finish;
  end

endmodule
